// File: sv/ccol_pkg.sv
// ============================================================================
// ccol_pkg
// Shared widths, selector codes and stage payload types for the circle
// collision test pipeline.
// ============================================================================
package ccol_pkg;

	// Coordinate width; radii and half extents are one bit narrower.
	localparam int COORD_BITS = 16;
	localparam int RAD_BITS   = COORD_BITS - 1;
	// Rotation terms are Q1.14.
	localparam int TRIG_BITS  = 16;
	localparam int TRIG_FRAC  = 14;
	localparam int ROUND_HALF = 1 << (TRIG_FRAC - 1);

	// Offset between centers, one bit wider than a coordinate.
	localparam int DIFF_BITS  = COORD_BITS + 1;
	// One rotation product and the sum of two of them.
	localparam int PROD_BITS  = DIFF_BITS + TRIG_BITS;
	localparam int SUM_BITS   = PROD_BITS + 1;
	// Rotated coordinate after rounding back to Q.4.
	localparam int ROT_BITS   = SUM_BITS - TRIG_FRAC;
	// Excess distance outside the clamp box.
	localparam int EXC_BITS   = ROT_BITS + 1;
	localparam int SQ_BITS    = 2 * EXC_BITS;
	localparam int DIST_BITS  = SQ_BITS + 1;
	// Radius sum and its square.
	localparam int RSUM_BITS  = COORD_BITS;
	localparam int RSQ_BITS   = 2 * RSUM_BITS;

	// Test selector codes.
	localparam logic [1:0] FUNC_RECT   = 2'd0;
	localparam logic [1:0] FUNC_CIRCLE = 2'd1;
	localparam logic [1:0] FUNC_POINT  = 2'd2;

	// Item handed from the rotation half to the distance half.
	typedef struct packed {
		logic [1:0]                  func;
		logic signed [DIFF_BITS-1:0] dx;
		logic signed [DIFF_BITS-1:0] dy;
		logic signed [ROT_BITS-1:0]  u;
		logic signed [ROT_BITS-1:0]  v;
		logic [RSUM_BITS-1:0]        radius;
		logic [RAD_BITS-1:0]         half_width;
		logic [RAD_BITS-1:0]         half_height;
	} rot_item_t;

endpackage

// File: sv/ccol_rotate.sv
// ============================================================================
// ccol_rotate
// Three pipeline stages: center offset and radius sum, the four rotation
// products, then rounding of the rotated offset back to Q.4.
// ============================================================================
module ccol_rotate import ccol_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [1:0]                   func,
	input  logic signed [COORD_BITS-1:0] circle_x,
	input  logic signed [COORD_BITS-1:0] circle_y,
	input  logic [RAD_BITS-1:0]          circle_radius,
	input  logic signed [COORD_BITS-1:0] other_x,
	input  logic signed [COORD_BITS-1:0] other_y,
	input  logic [RAD_BITS-1:0]          other_radius,
	input  logic [RAD_BITS-1:0]          half_width,
	input  logic [RAD_BITS-1:0]          half_height,
	input  logic signed [TRIG_BITS-1:0]  rect_cos,
	input  logic signed [TRIG_BITS-1:0]  rect_sin,
	output logic                         rot_valid,
	input  logic                         rot_stall,
	output rot_item_t                    rot_item
);

	logic move_s1, move_s2, move_s3;
	logic valid_s1, valid_s2, valid_s3;

	logic [1:0]                  func_s1, func_s2, func_s3;
	logic signed [DIFF_BITS-1:0] dx_s1, dy_s1, dx_s2, dy_s2, dx_s3, dy_s3;
	logic [RSUM_BITS-1:0]        radius_s1, radius_s2, radius_s3;
	logic [RAD_BITS-1:0]         hw_s1, hh_s1, hw_s2, hh_s2, hw_s3, hh_s3;
	logic signed [TRIG_BITS-1:0] cos_s1, sin_s1;
	logic signed [PROD_BITS-1:0] pxc_s2, pys_s2, pyc_s2, pxs_s2;
	logic signed [ROT_BITS-1:0]  u_s3, v_s3;

	logic [RSUM_BITS-1:0]        radius_sum;
	logic signed [SUM_BITS-1:0]  u_sum, v_sum;

	// A stage takes a new item when it is empty or its item moves on.
	assign move_s3   = !valid_s3 || !rot_stall;
	assign move_s2   = !valid_s2 || move_s3;
	assign move_s1   = !valid_s1 || move_s2;
	assign req_stall = !move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (move_s1) valid_s1 <= req_valid;
			if (move_s2) valid_s2 <= valid_s1;
			if (move_s3) valid_s3 <= valid_s2;
		end
	end

	// The second radius only counts in the circle against circle test.
	always_comb begin
		radius_sum = RSUM_BITS'(circle_radius);
		if (func == FUNC_CIRCLE) begin
			radius_sum = RSUM_BITS'(circle_radius) + RSUM_BITS'(other_radius);
		end
	end

	// Stage 1: offset of the circle center from the other center.
	always_ff @(posedge clk) begin
		if (move_s1) begin
			func_s1   <= func;
			dx_s1     <= DIFF_BITS'(circle_x) - DIFF_BITS'(other_x);
			dy_s1     <= DIFF_BITS'(circle_y) - DIFF_BITS'(other_y);
			radius_s1 <= radius_sum;
			hw_s1     <= half_width;
			hh_s1     <= half_height;
			cos_s1    <= rect_cos;
			sin_s1    <= rect_sin;
		end
	end

	// Stage 2: the four products of the rotation by the negated angle.
	always_ff @(posedge clk) begin
		if (move_s2) begin
			func_s2   <= func_s1;
			dx_s2     <= dx_s1;
			dy_s2     <= dy_s1;
			radius_s2 <= radius_s1;
			hw_s2     <= hw_s1;
			hh_s2     <= hh_s1;
			pxc_s2    <= PROD_BITS'(dx_s1 * cos_s1);
			pys_s2    <= PROD_BITS'(dy_s1 * sin_s1);
			pyc_s2    <= PROD_BITS'(dy_s1 * cos_s1);
			pxs_s2    <= PROD_BITS'(dx_s1 * sin_s1);
		end
	end

	// Rounding adds one half and floors; ties go toward plus infinity.
	assign u_sum = SUM_BITS'(pxc_s2) + SUM_BITS'(pys_s2) + SUM_BITS'(ROUND_HALF);
	assign v_sum = SUM_BITS'(pyc_s2) - SUM_BITS'(pxs_s2) + SUM_BITS'(ROUND_HALF);

	// Stage 3: rotated offset in rectangle coordinates.
	always_ff @(posedge clk) begin
		if (move_s3) begin
			func_s3   <= func_s2;
			dx_s3     <= dx_s2;
			dy_s3     <= dy_s2;
			radius_s3 <= radius_s2;
			hw_s3     <= hw_s2;
			hh_s3     <= hh_s2;
			u_s3      <= u_sum[SUM_BITS-1:TRIG_FRAC];
			v_s3      <= v_sum[SUM_BITS-1:TRIG_FRAC];
		end
	end

	assign rot_valid            = valid_s3;
	assign rot_item.func        = func_s3;
	assign rot_item.dx          = dx_s3;
	assign rot_item.dy          = dy_s3;
	assign rot_item.u           = u_s3;
	assign rot_item.v           = v_s3;
	assign rot_item.radius      = radius_s3;
	assign rot_item.half_width  = hw_s3;
	assign rot_item.half_height = hh_s3;

endmodule

// File: sv/ccol_dist.sv
// ============================================================================
// ccol_dist
// Three pipeline stages: excess offset outside the clamp box, squares of
// the offset and the radius, then the strict distance compare.
// ============================================================================
module ccol_dist import ccol_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rot_valid,
	output logic      rot_stall,
	input  rot_item_t rot_item,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output logic      hit
);

	logic move_s4, move_s5, move_s6;
	logic valid_s4, valid_s5, valid_s6;

	logic                        used_s4, used_s5;
	logic signed [EXC_BITS-1:0]  ex_s4, ey_s4;
	logic [RSUM_BITS-1:0]        radius_s4;
	logic [SQ_BITS-1:0]          sqx_s5, sqy_s5;
	logic [RSQ_BITS-1:0]         rsq_s5;
	logic                        hit_s6;

	logic signed [EXC_BITS-1:0]  u_ext, v_ext, hw_ext, hh_ext;
	logic signed [EXC_BITS-1:0]  ex_next, ey_next;
	logic [EXC_BITS-1:0]         mag_x, mag_y;
	logic [DIST_BITS-1:0]        dist_sq;

	// Same stage handshake as the rotation half.
	assign move_s6   = !valid_s6 || !rsp_stall;
	assign move_s5   = !valid_s5 || move_s6;
	assign move_s4   = !valid_s4 || move_s5;
	assign rot_stall = !move_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (move_s4) valid_s4 <= rot_valid;
			if (move_s5) valid_s5 <= valid_s4;
			if (move_s6) valid_s6 <= valid_s5;
		end
	end

	// Distance from the rotated point to the box is the part of each
	// coordinate that lies beyond the half extent; other tests use the center offset.
	always_comb begin
		u_ext  = EXC_BITS'(rot_item.u);
		v_ext  = EXC_BITS'(rot_item.v);
		hw_ext = EXC_BITS'(rot_item.half_width);
		hh_ext = EXC_BITS'(rot_item.half_height);
		if (rot_item.func == FUNC_RECT) begin
			if (u_ext > hw_ext) begin
				ex_next = u_ext - hw_ext;
			end else if (u_ext < -hw_ext) begin
				ex_next = u_ext + hw_ext;
			end else begin
				ex_next = '0;
			end
			if (v_ext > hh_ext) begin
				ey_next = v_ext - hh_ext;
			end else if (v_ext < -hh_ext) begin
				ey_next = v_ext + hh_ext;
			end else begin
				ey_next = '0;
			end
		end else begin
			ex_next = EXC_BITS'(rot_item.dx);
			ey_next = EXC_BITS'(rot_item.dy);
		end
	end

	// Stage 4: offset to be measured and whether the selector is known.
	always_ff @(posedge clk) begin
		if (move_s4) begin
			used_s4   <= (rot_item.func == FUNC_RECT) || (rot_item.func == FUNC_CIRCLE) ||
				(rot_item.func == FUNC_POINT);
			ex_s4     <= ex_next;
			ey_s4     <= ey_next;
			radius_s4 <= rot_item.radius;
		end
	end

	assign mag_x = ex_s4[EXC_BITS-1] ? EXC_BITS'(-ex_s4) : EXC_BITS'(ex_s4);
	assign mag_y = ey_s4[EXC_BITS-1] ? EXC_BITS'(-ey_s4) : EXC_BITS'(ey_s4);

	// Stage 5: squares of both offsets and of the radius.
	always_ff @(posedge clk) begin
		if (move_s5) begin
			used_s5 <= used_s4;
			sqx_s5  <= SQ_BITS'(mag_x) * SQ_BITS'(mag_x);
			sqy_s5  <= SQ_BITS'(mag_y) * SQ_BITS'(mag_y);
			rsq_s5  <= RSQ_BITS'(radius_s4) * RSQ_BITS'(radius_s4);
		end
	end

	assign dist_sq = DIST_BITS'(sqx_s5) + DIST_BITS'(sqy_s5);

	// Stage 6: strict compare; an unknown selector never hits.
	always_ff @(posedge clk) begin
		if (move_s6) begin
			hit_s6 <= used_s5 && (dist_sq < DIST_BITS'(rsq_s5));
		end
	end

	assign rsp_valid = valid_s6;
	assign hit       = hit_s6;

endmodule

// File: sv/circle_collision_test.sv
// ============================================================================
// circle_collision_test
// Overlap test of a circle against a rotated rectangle, a circle or a point.
// ============================================================================
// An accepted item moves through stage registers s1 to s6 to its result.
// Throughput: one item per cycle unless a held result backs up the stages.
// A stalled result holds only the stages behind it that are full.
// Reset: arst_n clears all stage valid bits; the data registers are not reset.
module circle_collision_test import ccol_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [1:0]                   func,
	input  logic signed [COORD_BITS-1:0] circle_x,
	input  logic signed [COORD_BITS-1:0] circle_y,
	input  logic [RAD_BITS-1:0]          circle_radius,
	input  logic signed [COORD_BITS-1:0] other_x,
	input  logic signed [COORD_BITS-1:0] other_y,
	input  logic [RAD_BITS-1:0]          other_radius,
	input  logic [RAD_BITS-1:0]          half_width,
	input  logic [RAD_BITS-1:0]          half_height,
	input  logic signed [TRIG_BITS-1:0]  rect_cos,
	input  logic signed [TRIG_BITS-1:0]  rect_sin,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic                         hit
);

	logic      rot_valid;
	logic      rot_stall;
	rot_item_t rot_item;

	// Offset, rotation and rounding.
	ccol_rotate u_rotate (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.func          (func),
		.circle_x      (circle_x),
		.circle_y      (circle_y),
		.circle_radius (circle_radius),
		.other_x       (other_x),
		.other_y       (other_y),
		.other_radius  (other_radius),
		.half_width    (half_width),
		.half_height   (half_height),
		.rect_cos      (rect_cos),
		.rect_sin      (rect_sin),
		.rot_valid     (rot_valid),
		.rot_stall     (rot_stall),
		.rot_item      (rot_item)
	);

	// Clamp, squares and compare.
	ccol_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.rot_valid (rot_valid),
		.rot_stall (rot_stall),
		.rot_item  (rot_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.hit       (hit)
	);

`ifndef NO_ASSERTIONS
	// An empty output stage lets the whole pipe move.
	a_empty_out_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall)
		else $error("input stalled while the output stage is empty");

	// The input stalls only behind a result that is held at the output.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (rsp_valid && rsp_stall))
		else $error("input stalled without a held result");

	// The middle handshake stalls only when the output is held too.
	a_mid_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rot_stall |-> (rsp_valid && rsp_stall))
		else $error("inner stall without a held result");
`endif

endmodule

// File: tb/sv/ccol_hit_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// ccol_hit_checker
// Watches both channels of the circle collision test block. It predicts the
// hit bit of every accepted query and checks it against the returned result.
// ============================================================================
module ccol_hit_checker import ccol_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic                         req_stall,
	input  logic [1:0]                   func,
	input  logic signed [COORD_BITS-1:0] circle_x,
	input  logic signed [COORD_BITS-1:0] circle_y,
	input  logic [RAD_BITS-1:0]          circle_radius,
	input  logic signed [COORD_BITS-1:0] other_x,
	input  logic signed [COORD_BITS-1:0] other_y,
	input  logic [RAD_BITS-1:0]          other_radius,
	input  logic [RAD_BITS-1:0]          half_width,
	input  logic [RAD_BITS-1:0]          half_height,
	input  logic signed [TRIG_BITS-1:0]  rect_cos,
	input  logic signed [TRIG_BITS-1:0]  rect_sin,
	input  logic                         rsp_valid,
	input  logic                         rsp_stall,
	input  logic                         hit,
	output int                           mismatch_count,
	output int                           hits_outstanding
);

	// Hit bits predicted for queries that have been accepted but not answered.
	logic pending_hits[$];
	int   result_index = 0;
	int   errors = 0;

	assign mismatch_count = errors;

	// Overlap test at full width. Every intermediate fits easily in 64 bits.
	function automatic logic overlap_hit(
		input logic [1:0]                   sel,
		input logic signed [COORD_BITS-1:0] cx,
		input logic signed [COORD_BITS-1:0] cy,
		input logic [RAD_BITS-1:0]          cr,
		input logic signed [COORD_BITS-1:0] ox,
		input logic signed [COORD_BITS-1:0] oy,
		input logic [RAD_BITS-1:0]          orad,
		input logic [RAD_BITS-1:0]          hw,
		input logic [RAD_BITS-1:0]          hh,
		input logic signed [TRIG_BITS-1:0]  cs,
		input logic signed [TRIG_BITS-1:0]  sn
	);
		longint dx, dy, u, v, qx, qy, ex, ey, rad, hwl, hhl, csl, snl;
		dx  = longint'(cx) - longint'(ox);
		dy  = longint'(cy) - longint'(oy);
		csl = longint'(cs);
		snl = longint'(sn);
		hwl = longint'(hw);
		hhl = longint'(hh);
		case (sel)
			FUNC_RECT: begin
				// Rotate the offset by the negated angle and round to Q.4,
				// ties going toward positive infinity.
				u  = (dx * csl + dy * snl + ROUND_HALF) >>> TRIG_FRAC;
				v  = (dy * csl - dx * snl + ROUND_HALF) >>> TRIG_FRAC;
				qx = (u < -hwl) ? -hwl : ((u > hwl) ? hwl : u);
				qy = (v < -hhl) ? -hhl : ((v > hhl) ? hhl : v);
				ex = u - qx;
				ey = v - qy;
				rad = longint'(cr);
				return (ex * ex + ey * ey < rad * rad);
			end
			FUNC_CIRCLE: begin
				rad = longint'(cr) + longint'(orad);
				return (dx * dx + dy * dy < rad * rad);
			end
			FUNC_POINT: begin
				rad = longint'(cr);
				return (dx * dx + dy * dy < rad * rad);
			end
			default: return 1'b0;
		endcase
	endfunction

	// Only the first few mismatches are printed; the rest are counted.
	task automatic note_mismatch(input string what, input logic exp_hit,
			input logic got_hit);
		errors++;
		if (errors <= 10)
			$display("%t: %s at result %0d: expected hit %0b, got %0b",
				$time, what, result_index, exp_hit, got_hit);
	endtask

	// Answers are checked before new queries are queued so that a stray
	// result can never be matched against a query of the same cycle.
	always @(posedge clk) begin : track_hits
		logic exp_hit;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_hits.size() == 0) begin
					note_mismatch("unexpected result", 1'bx, hit);
				end else begin
					exp_hit = pending_hits.pop_front();
					if (hit !== exp_hit)
						note_mismatch("hit mismatch", exp_hit, hit);
				end
				result_index++;
			end
			if (req_valid && !req_stall)
				pending_hits.push_back(overlap_hit(func, circle_x, circle_y,
					circle_radius, other_x, other_y, other_radius, half_width,
					half_height, rect_cos, rect_sin));
			hits_outstanding <= pending_hits.size();
		end
	end

endmodule

// File: tb/sv/tb_circle_collision_test.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_circle_collision_test
// Drives overlap queries into the circle collision test block: a directed
// set of edge cases and then random queries in bursts, with random stalls
// on the result side. A separate checker predicts and compares every hit.
// ============================================================================
module tb_circle_collision_test;
	import ccol_pkg::*;

	localparam logic [1:0] SEL_UNUSED   = 2'd3;
	localparam int         RANDOM_ITEMS = 1030;
	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         SETTLE_CYCLES = 20;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	typedef struct {
		logic [1:0]                   sel;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic [RAD_BITS-1:0]          cr;
		logic signed [COORD_BITS-1:0] ox;
		logic signed [COORD_BITS-1:0] oy;
		logic [RAD_BITS-1:0]          orad;
		logic [RAD_BITS-1:0]          hw;
		logic [RAD_BITS-1:0]          hh;
		logic signed [TRIG_BITS-1:0]  cs;
		logic signed [TRIG_BITS-1:0]  sn;
	} query_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [1:0] func = '0;
	logic signed [COORD_BITS-1:0] circle_x = '0;
	logic signed [COORD_BITS-1:0] circle_y = '0;
	logic [RAD_BITS-1:0] circle_radius = '0;
	logic signed [COORD_BITS-1:0] other_x = '0;
	logic signed [COORD_BITS-1:0] other_y = '0;
	logic [RAD_BITS-1:0] other_radius = '0;
	logic [RAD_BITS-1:0] half_width = '0;
	logic [RAD_BITS-1:0] half_height = '0;
	logic signed [TRIG_BITS-1:0] rect_cos = '0;
	logic signed [TRIG_BITS-1:0] rect_sin = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic hit;

	int mismatch_count;
	int hits_outstanding;
	int cycle_count = 0;
	int burst_left = 0;

	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	circle_collision_test dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.func          (func),
		.circle_x      (circle_x),
		.circle_y      (circle_y),
		.circle_radius (circle_radius),
		.other_x       (other_x),
		.other_y       (other_y),
		.other_radius  (other_radius),
		.half_width    (half_width),
		.half_height   (half_height),
		.rect_cos      (rect_cos),
		.rect_sin      (rect_sin),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.hit           (hit)
	);

	ccol_hit_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.func             (func),
		.circle_x         (circle_x),
		.circle_y         (circle_y),
		.circle_radius    (circle_radius),
		.other_x          (other_x),
		.other_y          (other_y),
		.other_radius     (other_radius),
		.half_width       (half_width),
		.half_height      (half_height),
		.rect_cos         (rect_cos),
		.rect_sin         (rect_sin),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.hit              (hit),
		.mismatch_count   (mismatch_count),
		.hits_outstanding (hits_outstanding)
	);

	// Result-side back pressure: a random mode is held for a random span,
	// from no stalls at all to stalling most of the time.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(32, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:  rsp_stall <= 1'b0;
			STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
			default:     rsp_stall <= stall_left[2];
		endcase
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic query_t make_query(input logic [1:0] sel, input int cx,
			input int cy, input int cr, input int ox, input int oy,
			input int orad, input int hw, input int hh, input int cs,
			input int sn);
		query_t q;
		q.sel  = sel;
		q.cx   = COORD_BITS'(cx);
		q.cy   = COORD_BITS'(cy);
		q.cr   = RAD_BITS'(cr);
		q.ox   = COORD_BITS'(ox);
		q.oy   = COORD_BITS'(oy);
		q.orad = RAD_BITS'(orad);
		q.hw   = RAD_BITS'(hw);
		q.hh   = RAD_BITS'(hh);
		q.cs   = TRIG_BITS'(cs);
		q.sn   = TRIG_BITS'(sn);
		return q;
	endfunction

	// Most queries place the shapes close together at one of a few scales so
	// that hits and misses both occur; the rest are fully random.
	function automatic query_t random_query();
		query_t q;
		int     pick, scale, off_x, off_y;
		real    ang;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			q.sel = SEL_UNUSED;
		else if (pick < 9)
			q.sel = FUNC_RECT;
		else if (pick < 15)
			q.sel = FUNC_CIRCLE;
		else
			q.sel = FUNC_POINT;
		q.cx = COORD_BITS'($urandom);
		q.cy = COORD_BITS'($urandom);
		if ($urandom_range(0, 99) < 60) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: scale = 255;
				6, 7, 8:          scale = 4095;
				default:          scale = 32767;
			endcase
			off_x  = int'($urandom_range(0, 2 * scale)) - scale;
			off_y  = int'($urandom_range(0, 2 * scale)) - scale;
			q.ox   = COORD_BITS'(int'(q.cx) + off_x);
			q.oy   = COORD_BITS'(int'(q.cy) + off_y);
			q.cr   = RAD_BITS'($urandom_range(0, scale));
			q.orad = RAD_BITS'($urandom_range(0, scale));
			q.hw   = RAD_BITS'($urandom_range(0, scale));
			q.hh   = RAD_BITS'($urandom_range(0, scale));
		end else begin
			q.ox   = COORD_BITS'($urandom);
			q.oy   = COORD_BITS'($urandom);
			q.cr   = RAD_BITS'($urandom);
			q.orad = RAD_BITS'($urandom);
			q.hw   = RAD_BITS'($urandom);
			q.hh   = RAD_BITS'($urandom);
		end
		// Rotation: mostly a proper unit pair, sometimes arbitrary values.
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			ang  = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
			q.cs = TRIG_BITS'($rtoi($floor(16384.0 * $cos(ang) + 0.5)));
			q.sn = TRIG_BITS'($rtoi($floor(16384.0 * $sin(ang) + 0.5)));
		end else begin
			q.cs = TRIG_BITS'($urandom);
			q.sn = TRIG_BITS'($urandom);
		end
		return q;
	endfunction

	// Presents one query, waits for it to be taken, and then either keeps
	// the burst going or drops valid for a random gap.
	task automatic offer_query(input query_t q);
		int gap;
		func          <= q.sel;
		circle_x      <= q.cx;
		circle_y      <= q.cy;
		circle_radius <= q.cr;
		other_x       <= q.ox;
		other_y       <= q.oy;
		other_radius  <= q.orad;
		half_width    <= q.hw;
		half_height   <= q.hh;
		rect_cos      <= q.cs;
		rect_sin      <= q.sn;
		req_valid     <= 1'b1;
		do @(posedge clk); while (req_stall);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Holds off new queries until every outstanding hit has come back.
	task automatic drain_hits();
		req_valid <= 1'b0;
		@(posedge clk);
		while (hits_outstanding != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int n;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Rectangle: centered overlap, edge contact, just inside, corner.
		offer_query(make_query(FUNC_RECT, 0, 0, 16, 0, 0, 0, 32, 32, 16384, 0));
		offer_query(make_query(FUNC_RECT, 48, 0, 16, 0, 0, 0, 32, 32, 16384, 0));
		offer_query(make_query(FUNC_RECT, 47, 0, 16, 0, 0, 0, 32, 32, 16384, 0));
		offer_query(make_query(FUNC_RECT, 40, 40, 12, 0, 0, 0, 32, 32, 16384, 0));
		// Quarter turn, half turn and forty-five degrees.
		offer_query(make_query(FUNC_RECT, 0, 60, 16, 0, 0, 0, 64, 16, 0, 16384));
		offer_query(make_query(FUNC_RECT, -70, 5, 16, 0, 0, 0, 64, 16, -16384, 0));
		offer_query(make_query(FUNC_RECT, 100, 0, 20, 0, 0, 0, 80, 10,
			11585, 11585));
		// Rounding ties on both sides of zero.
		offer_query(make_query(FUNC_RECT, 1, 0, 2, 0, 0, 0, 0, 0, 8192, 0));
		offer_query(make_query(FUNC_RECT, -1, 0, 1, 0, 0, 0, 0, 0, 8192, 0));
		// Rotation terms that are not a unit pair.
		offer_query(make_query(FUNC_RECT, 500, -300, 64, -20, 30, 0, 200, 100,
			32767, -32768));
		// Field extremes.
		offer_query(make_query(FUNC_RECT, 32767, 32767, 32767, -32768, -32768, 0,
			32767, 32767, -32768, -32768));
		offer_query(make_query(FUNC_RECT, -32768, -32768, 32767, 32767, 32767,
			32767, 0, 0, 32767, 32767));
		// A zero radius never hits, even inside the rectangle.
		offer_query(make_query(FUNC_RECT, 0, 0, 0, 0, 0, 0, 100, 100, 16384, 0));
		// Two circles: exact contact, just overlapping, extremes, zero radii.
		offer_query(make_query(FUNC_CIRCLE, 100, 0, 30, 0, 0, 70, 0, 0, 0, 0));
		offer_query(make_query(FUNC_CIRCLE, 99, 0, 30, 0, 0, 70, 0, 0, 0, 0));
		offer_query(make_query(FUNC_CIRCLE, 32767, 32767, 32767, -32768, -32768,
			32767, 0, 0, 0, 0));
		offer_query(make_query(FUNC_CIRCLE, 7, 7, 0, 7, 7, 0, 0, 0, 0, 0));
		// Point: on the rim, just inside, zero radius, extremes.
		offer_query(make_query(FUNC_POINT, 0, 0, 50, 30, 40, 0, 0, 0, 0, 0));
		offer_query(make_query(FUNC_POINT, 0, 0, 51, 30, 40, 0, 0, 0, 0, 0));
		offer_query(make_query(FUNC_POINT, 5, 5, 0, 5, 5, 0, 0, 0, 0, 0));
		offer_query(make_query(FUNC_POINT, -32768, 32767, 32767, 32767, -32768,
			0, 0, 0, 0, 0));
		// The unused selector answers no hit even for overlapping shapes.
		offer_query(make_query(SEL_UNUSED, 0, 0, 100, 0, 0, 100, 100, 100,
			16384, 0));
		drain_hits();

		// Random queries, with one full drain halfway through.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			offer_query(random_query());
			if (n == RANDOM_ITEMS / 2)
				drain_hits();
		end
		drain_hits();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: files.f
sv/ccol_pkg.sv
sv/ccol_rotate.sv
sv/ccol_dist.sv
sv/circle_collision_test.sv
tb/sv/ccol_hit_checker.sv
tb/sv/tb_circle_collision_test.sv
